// File: hw/rtl/etud_pkg.sv
package etud_pkg;

    // reciprocal constants for divide-by-constant, each exact over its input range
    localparam logic [25:0] RCP_675  = 26'd50903317;  // x < 2^25, shift 35
    localparam logic [16:0] RCP_7    = 17'd74899;     // x < 2^16, shift 19
    localparam logic [15:0] RCP_1461 = 16'd45934;     // x < 2^16, shift 26
    localparam logic [12:0] RCP_225  = 13'd4661;      // x < 5400, shift 20
    localparam logic [10:0] RCP_15   = 11'd1093;      // x < 900,  shift 14

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;

    // day count is rebased to 1968-01-01, the start of a four-year cycle
    localparam logic [9:0]  DAYS_1968_TO_1970 = 10'd731;
    localparam logic [7:0]  YEAR_1968_OFS     = 8'd68;
    // 2100 is not leap: from its March 1 on, one day is inserted so the
    // four-year cycle arithmetic stays uniform
    localparam logic [15:0] DAY_2100_MAR1 = 16'd47541;
    localparam logic [5:0]  QUAD_2100     = 6'd33;

    localparam logic [10:0] QUAD_YEAR1 = 11'd366;
    localparam logic [10:0] QUAD_YEAR2 = 11'd731;
    localparam logic [10:0] QUAD_YEAR3 = 11'd1096;

    typedef logic [8:0] t_doy;

    localparam t_doy MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    function automatic t_doy month_start(input logic [3:0] mon, input logic leap);
        t_doy base;
        base = MONTH_START[mon];
        if (leap && (mon >= 4'd2)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// File: hw/rtl/epoch_seconds_to_utc_date.sv
// Pipeline: an accepted input transaction passes through six register stages
// (s1 to s6) before o_valid rises with its result.
// Throughput: one transaction per cycle when not stalled; each of the six stages
// is one level of constant multiplies (reciprocal divide) or the month lookup.
// i_stall with a waiting result freezes the whole pipeline.
// Reset (i_rst_n low, synchronous) clears the stage valid bits only.
module epoch_seconds_to_utc_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_second,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month_index,
    output logic [7:0]  o_years_since_1900,
    output logic [8:0]  o_day_of_year,
    output logic [2:0]  o_weekday
);
    import etud_pkg::*;

    logic [6:1] r_vld;
    logic       n_adv;

    // stage 1: days = t / 86400
    logic [50:0] n_p1;
    logic [15:0] r_s1_days;
    logic [16:0] r_s1_tlo;

    // stage 2: time of day
    logic [16:0] n_s2_dm;
    logic [15:0] r_s2_days;
    logic [16:0] r_s2_tod;

    // stage 3: weekday quotient, cycle index, hour
    logic [15:0] n_s3_x7;
    logic [31:0] n_s3_pw;
    logic [15:0] n_s3_dp;
    logic [31:0] n_s3_pc;
    logic [24:0] n_s3_ph;
    logic        n_s3_adj;
    logic [15:0] r_s3_x7;
    logic [12:0] r_s3_wq;
    logic [15:0] r_s3_dp;
    logic [5:0]  r_s3_c;
    logic        r_s3_adj;
    logic [4:0]  r_s3_hour;
    logic [16:0] r_s3_tod;

    // stage 4: remainders
    logic [15:0] n_s4_w7;
    logic [15:0] n_s4_wd;
    logic [15:0] n_s4_c1461;
    logic [15:0] n_s4_r;
    logic [16:0] n_s4_h3600;
    logic [16:0] n_s4_rem;
    logic [2:0]  r_s4_wd;
    logic [10:0] r_s4_r;
    logic [5:0]  r_s4_c;
    logic        r_s4_adj;
    logic [4:0]  r_s4_hour;
    logic [11:0] r_s4_rem;

    // stage 5: year within cycle, minute
    logic [1:0]  n_s5_yoff;
    logic [10:0] n_s5_base;
    logic [10:0] n_s5_doy;
    logic        n_s5_fix;
    logic [20:0] n_s5_pm;
    t_doy        r_s5_doy;
    t_doy        r_s5_yday;
    logic        r_s5_leap;
    logic [7:0]  r_s5_year;
    logic [5:0]  r_s5_minute;
    logic [11:0] r_s5_rem;
    logic [4:0]  r_s5_hour;
    logic [2:0]  r_s5_wd;

    // stage 6: month, day, second
    logic [11:0] n_s6_m60;
    logic [11:0] n_s6_sec;
    logic [3:0]  n_s6_mon;
    logic [4:0]  n_s6_mday;
    logic [5:0]  r_s6_second;
    logic [5:0]  r_s6_minute;
    logic [4:0]  r_s6_hour;
    logic [4:0]  r_s6_mday;
    logic [3:0]  r_s6_mon;
    logic [7:0]  r_s6_year;
    t_doy        r_s6_yday;
    logic [2:0]  r_s6_wd;

    assign n_adv   = !(r_vld[6] && i_stall);
    assign o_stall = !n_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_adv) begin
            r_vld <= {r_vld[5:1], i_valid};
        end
    end

    always_comb begin
        n_p1 = 51'(i_epoch_seconds[31:7]) * 51'(RCP_675);
    end

    always_comb begin
        // only the low 17 bits matter: the true remainder is below 2^17
        n_s2_dm = 17'(r_s1_days) * SECS_PER_DAY;
    end

    always_comb begin
        n_s3_x7  = r_s2_days + 16'd4;
        n_s3_pw  = 32'(n_s3_x7) * 32'(RCP_7);
        n_s3_adj = (r_s2_days >= DAY_2100_MAR1);
        n_s3_dp  = r_s2_days + 16'(DAYS_1968_TO_1970) + 16'(n_s3_adj);
        n_s3_pc  = 32'(n_s3_dp) * 32'(RCP_1461);
        n_s3_ph  = 25'(r_s2_tod[16:4]) * 25'(RCP_225);
    end

    always_comb begin
        n_s4_w7    = 16'(r_s3_wq) * 16'd7;
        n_s4_wd    = r_s3_x7 - n_s4_w7;
        n_s4_c1461 = 16'(r_s3_c) * 16'(DAYS_PER_QUAD);
        n_s4_r     = r_s3_dp - n_s4_c1461;
        n_s4_h3600 = 17'(r_s3_hour) * 17'(SECS_PER_HOUR);
        n_s4_rem   = r_s3_tod - n_s4_h3600;
    end

    always_comb begin
        if (r_s4_r < QUAD_YEAR1) begin
            n_s5_yoff = 2'd0;
            n_s5_base = '0;
        end else if (r_s4_r < QUAD_YEAR2) begin
            n_s5_yoff = 2'd1;
            n_s5_base = QUAD_YEAR1;
        end else if (r_s4_r < QUAD_YEAR3) begin
            n_s5_yoff = 2'd2;
            n_s5_base = QUAD_YEAR2;
        end else begin
            n_s5_yoff = 2'd3;
            n_s5_base = QUAD_YEAR3;
        end
        n_s5_doy = r_s4_r - n_s5_base;
        // inside 2100 after Feb, the inserted day is taken back out of the day of year
        n_s5_fix = r_s4_adj && (r_s4_c == QUAD_2100) && (n_s5_yoff == 2'd0);
        n_s5_pm  = 21'(r_s4_rem[11:2]) * 21'(RCP_15);
    end

    always_comb begin
        n_s6_m60 = 12'(r_s5_minute) * 12'(SECS_PER_MIN);
        n_s6_sec = r_s5_rem - n_s6_m60;
    end

    etud_month u_month (
        .i_doy   (r_s5_doy),
        .i_leap  (r_s5_leap),
        .o_month (n_s6_mon),
        .o_mday  (n_s6_mday)
    );

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_s1_days   <= n_p1[50:35];
            r_s1_tlo    <= i_epoch_seconds[16:0];

            r_s2_days   <= r_s1_days;
            r_s2_tod    <= r_s1_tlo - n_s2_dm;

            r_s3_x7     <= n_s3_x7;
            r_s3_wq     <= n_s3_pw[31:19];
            r_s3_dp     <= n_s3_dp;
            r_s3_c      <= n_s3_pc[31:26];
            r_s3_adj    <= n_s3_adj;
            r_s3_hour   <= n_s3_ph[24:20];
            r_s3_tod    <= r_s2_tod;

            r_s4_wd     <= n_s4_wd[2:0];
            r_s4_r      <= n_s4_r[10:0];
            r_s4_c      <= r_s3_c;
            r_s4_adj    <= r_s3_adj;
            r_s4_hour   <= r_s3_hour;
            r_s4_rem    <= n_s4_rem[11:0];

            r_s5_doy    <= n_s5_doy[8:0];
            r_s5_yday   <= n_s5_doy[8:0] - 9'(n_s5_fix);
            r_s5_leap   <= (n_s5_yoff == 2'd0);
            r_s5_year   <= YEAR_1968_OFS + {r_s4_c, 2'b00} + 8'(n_s5_yoff);
            r_s5_minute <= n_s5_pm[19:14];
            r_s5_rem    <= r_s4_rem;
            r_s5_hour   <= r_s4_hour;
            r_s5_wd     <= r_s4_wd;

            r_s6_second <= n_s6_sec[5:0];
            r_s6_minute <= r_s5_minute;
            r_s6_hour   <= r_s5_hour;
            r_s6_mday   <= n_s6_mday;
            r_s6_mon    <= n_s6_mon;
            r_s6_year   <= r_s5_year;
            r_s6_yday   <= r_s5_yday;
            r_s6_wd     <= r_s5_wd;
        end
    end

    assign o_valid            = r_vld[6];
    assign o_second           = r_s6_second;
    assign o_minute           = r_s6_minute;
    assign o_hour             = r_s6_hour;
    assign o_day_of_month     = r_s6_mday;
    assign o_month_index      = r_s6_mon;
    assign o_years_since_1900 = r_s6_year;
    assign o_day_of_year      = r_s6_yday;
    assign o_weekday          = r_s6_wd;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid bits not cleared by reset");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_second <= 6'd59) && (o_minute <= 6'd59) && (o_hour <= 5'd23))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month_index <= 4'd11) && (o_day_of_month >= 5'd1)
                    && (o_day_of_year <= 9'd365) && (o_weekday <= 3'd6)
                    && (o_years_since_1900 >= 8'd70) && (o_years_since_1900 <= 8'd206))
        else $error("date field out of range");

    a_early_days: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_day_of_year <= 9'd58)) |-> (o_month_index <= 4'd1))
        else $error("month inconsistent with day of year");

endmodule

// File: hw/rtl/etud_month.sv
module etud_month (
    input  etud_pkg::t_doy i_doy,
    input  logic           i_leap,
    output logic [3:0]     o_month,
    output logic [4:0]     o_mday
);
    import etud_pkg::*;

    t_doy n_start;
    t_doy n_diff;

    // month index = number of month starts after January at or below the day of year
    always_comb begin
        o_month = '0;
        for (int m = 1; m < 12; m++) begin
            if (i_doy >= month_start(4'(m), i_leap)) begin
                o_month = o_month + 4'd1;
            end
        end
    end

    always_comb begin
        n_start = month_start(o_month, i_leap);
        n_diff  = i_doy - n_start + 9'd1;
    end

    assign o_mday = n_diff[4:0];

endmodule

// File: tb/epoch_seconds_to_utc_date_test.sv
`timescale 1ns / 100ps

module epoch_seconds_to_utc_date_test;

    localparam int RANDOM_PER_PATTERN = 482;
    localparam int HOLD_CYCLES        = 300;
    localparam int SETTLE_CYCLES      = 12;
    localparam int QUIET_LIMIT        = 3000;
    localparam int MONTH_DAYS [12]    = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef enum int {
        GAP_NONE,
        GAP_SENDER,
        GAP_RECEIVER,
        GAP_BOTH
    } t_gap_mode;

    typedef struct {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day_of_month;
        logic [3:0] month_index;
        logic [7:0] years_since_1900;
        logic [8:0] day_of_year;
        logic [2:0] weekday;
    } t_calendar;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_epoch_seconds = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [5:0]  o_second;
    logic [5:0]  o_minute;
    logic [4:0]  o_hour;
    logic [4:0]  o_day_of_month;
    logic [3:0]  o_month_index;
    logic [7:0]  o_years_since_1900;
    logic [8:0]  o_day_of_year;
    logic [2:0]  o_weekday;

    t_gap_mode gap_mode = GAP_NONE;
    int        hold_requests = 0;
    int        hold_seen = 0;
    int        hold_left = 0;
    int        quiet_cycles = 0;

    always #2 i_clk = ~i_clk;

    epoch_seconds_to_utc_date u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_epoch_seconds    (i_epoch_seconds),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_second           (o_second),
        .o_minute           (o_minute),
        .o_hour             (o_hour),
        .o_day_of_month     (o_day_of_month),
        .o_month_index      (o_month_index),
        .o_years_since_1900 (o_years_since_1900),
        .o_day_of_year      (o_day_of_year),
        .o_weekday          (o_weekday)
    );

    function automatic bit leap_year(input int unsigned year);
        return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    endfunction

    function automatic int unsigned month_days(input int unsigned mon, input int unsigned year);
        if (mon == 1 && leap_year(year)) begin
            return 29;
        end
        return MONTH_DAYS[mon];
    endfunction

    // days from 1970-01-01 to the given date; month is 0-based
    function automatic longint day_number(input int unsigned year, input int unsigned mon,
                                          input int unsigned mday);
        longint days;
        days = 0;
        for (int unsigned y = 1970; y < year; y++) begin
            days += leap_year(y) ? 366 : 365;
        end
        for (int unsigned m = 0; m < mon; m++) begin
            days += month_days(m, year);
        end
        return days + mday - 1;
    endfunction

    class calendar_scoreboard;
        t_calendar pending[$];
        int        errors = 0;
        int        checked = 0;
        int        leap_days = 0;
        int        last_year = 1970;

        function t_calendar to_calendar(input logic [31:0] secs);
            int unsigned t;
            int unsigned days;
            int unsigned tod;
            int unsigned year;
            int unsigned rest;
            int unsigned mon;
            int unsigned ylen;
            t_calendar c;
            t    = secs;
            days = t / 86400;
            tod  = t % 86400;
            c.hour   = 5'(tod / 3600);
            c.minute = 6'((tod % 3600) / 60);
            c.second = 6'(tod % 60);
            year = 1970;
            rest = days;
            forever begin
                ylen = leap_year(year) ? 366 : 365;
                if (rest < ylen) begin
                    break;
                end
                rest -= ylen;
                year++;
            end
            c.day_of_year = 9'(rest);
            mon = 0;
            while (mon < 12) begin
                if (rest < month_days(mon, year)) begin
                    break;
                end
                rest -= month_days(mon, year);
                mon++;
            end
            c.day_of_month     = 5'(rest + 1);
            c.month_index      = 4'(mon);
            c.years_since_1900 = 8'(year - 1900);
            c.weekday          = 3'((days + 4) % 7);
            return c;
        endfunction

        function void note_input(input logic [31:0] secs);
            pending.push_back(to_calendar(secs));
        endfunction

        function void check_field(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input t_calendar got);
            t_calendar want;
            if (pending.size() == 0) begin
                $error("result transaction with no input outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.month_index == 1 && want.day_of_month == 29) begin
                leap_days++;
            end
            if (want.years_since_1900 + 1900 > last_year) begin
                last_year = want.years_since_1900 + 1900;
            end
            check_field("second", 32'(want.second), 32'(got.second));
            check_field("minute", 32'(want.minute), 32'(got.minute));
            check_field("hour", 32'(want.hour), 32'(got.hour));
            check_field("day_of_month", 32'(want.day_of_month), 32'(got.day_of_month));
            check_field("month_index", 32'(want.month_index), 32'(got.month_index));
            check_field("years_since_1900", 32'(want.years_since_1900),
                        32'(got.years_since_1900));
            check_field("day_of_year", 32'(want.day_of_year), 32'(got.day_of_year));
            check_field("weekday", 32'(want.weekday), 32'(got.weekday));
        endfunction
    endclass

    calendar_scoreboard dates = new();

    function automatic int sender_idle_pct();
        case (gap_mode)
            GAP_SENDER: return 80;
            GAP_BOTH:   return 8;
            default:    return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (gap_mode)
            GAP_RECEIVER: return 80;
            GAP_BOTH:     return 8;
            default:      return 0;
        endcase
    endfunction

    // mostly boundary-heavy timestamps; the rest spread over the full 32-bit range
    function automatic logic [31:0] pick_timestamp();
        longint      t;
        int unsigned year;
        int unsigned mon;
        year = $urandom_range(2106, 1970);
        mon  = $urandom_range(11, 0);
        case ($urandom_range(9, 0))
            0, 1, 2, 3: return $urandom();
            4: begin
                t = longint'($urandom_range(49710, 0)) * 86400;
                case ($urandom_range(3, 0))
                    0:       t += 0;
                    1:       t += 1;
                    2:       t += 86399;
                    default: t += $urandom_range(86399, 0);
                endcase
            end
            5, 6: t = (day_number(year, 0, 1) + $urandom_range(2, 0) - 1) * 86400
                      + $urandom_range(86399, 0);
            7: t = (day_number(year, 1, 28) + $urandom_range(2, 0)) * 86400
                   + $urandom_range(86399, 0);
            8: t = (day_number(year, mon, 1) - $urandom_range(1, 0)) * 86400
                   + ($urandom_range(1, 0) ? 86399 : 0);
            default: t = (day_number(year, 11, 31) * 86400) + $urandom_range(86399, 0);
        endcase
        if (t < 0 || t > 64'hFFFF_FFFF) begin
            return $urandom();
        end
        return t[31:0];
    endfunction

    task automatic send_timestamp(input logic [31:0] secs);
        i_valid         <= 1'b1;
        i_epoch_seconds <= secs;
        do @(posedge i_clk); while (o_stall);
        dates.note_input(secs);
        while ($urandom_range(99, 0) < sender_idle_pct()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_date(input int unsigned year, input int unsigned mon,
                             input int unsigned mday, input int unsigned tod);
        longint t;
        t = day_number(year, mon, mday) * 86400 + tod;
        send_timestamp(t[31:0]);
    endtask

    // hold the input until every outstanding conversion has come back
    task automatic drain();
        i_valid <= 1'b0;
        while (dates.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_side
        t_calendar seen;
        if (i_rst_n && o_valid && !i_stall) begin
            seen.second           = o_second;
            seen.minute           = o_minute;
            seen.hour             = o_hour;
            seen.day_of_month     = o_day_of_month;
            seen.month_index      = o_month_index;
            seen.years_since_1900 = o_years_since_1900;
            seen.day_of_year      = o_day_of_year;
            seen.weekday          = o_weekday;
            dates.check_result(seen);
        end
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99, 0) < receiver_stall_pct());
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("** epoch_seconds_to_utc_date: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes and calendar corner cases
        send_timestamp(32'h0000_0000);
        send_timestamp(32'hFFFF_FFFF);
        send_timestamp(32'd86399);
        send_timestamp(32'd86400);
        send_timestamp(32'h7FFF_FFFF);
        send_timestamp(32'h8000_0000);
        send_timestamp(32'hAAAA_AAAA);
        send_timestamp(32'h5555_5555);
        send_date(1970, 11, 31, 86399);
        send_date(1972, 1, 28, 86399);
        send_date(1972, 1, 29, 0);
        send_date(1972, 2, 1, 0);
        send_date(1972, 11, 31, 43200);
        send_date(1973, 0, 1, 0);
        send_date(2000, 1, 29, 3661);
        send_date(2000, 11, 31, 86399);
        send_date(2100, 1, 28, 86399);
        send_date(2100, 2, 1, 0);
        send_date(2100, 11, 31, 0);
        send_date(2101, 0, 1, 0);
        send_date(2104, 1, 29, 7322);
        send_date(2106, 1, 7, 0);
        send_date(2106, 1, 7, 23294);
        drain();

        for (int p = GAP_NONE; p <= GAP_BOTH; p++) begin
            gap_mode <= t_gap_mode'(p);
            for (int n = 0; n < RANDOM_PER_PATTERN; n++) begin
                // back the pipeline up while the input keeps offering
                if (p == GAP_NONE && n == 60) begin
                    hold_requests <= hold_requests + 1;
                end
                send_timestamp(pick_timestamp());
            end
            drain();
        end

        $display("Converted %0d timestamps (%0d landing on Feb 29, latest year %0d).",
                 dates.checked, dates.leap_days, dates.last_year);
        $display("Ran four idle/stall patterns, a %0d-cycle output hold-off and drain pauses.",
                 HOLD_CYCLES);
        if (dates.errors == 0) begin
            $display("** epoch_seconds_to_utc_date: PASSED **");
        end else begin
            $display("** epoch_seconds_to_utc_date: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/etud_pkg.sv
hw/rtl/etud_month.sv
hw/rtl/epoch_seconds_to_utc_date.sv
tb/epoch_seconds_to_utc_date_test.sv
